[rtl/u8sd_pkg.sv]
// Package for the UTF-8 stream decoder: result type, transfer bundle and lead-byte constants.
`default_nettype none
package u8sd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [3:0] COUNT_SAT  = 4'hF;

    localparam logic [2:0] LEN_BAD = 3'd0;
    localparam logic [2:0] LEN_1   = 3'd1;
    localparam logic [2:0] LEN_2   = 3'd2;
    localparam logic [2:0] LEN_3   = 3'd3;
    localparam logic [2:0] LEN_4   = 3'd4;
    localparam logic [2:0] LEN_5   = 3'd5;
    localparam logic [2:0] LEN_6   = 3'd6;

    typedef struct packed {
        logic [31:0] code_point;
        logic [3:0]  byte_count;
        logic        length_mismatch;
        logic        bad_lead;
        logic        last_of_run;
    } result_t;

    // Up to two results produced by one input byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  exp_len;
        logic        bad;
    } lead_t;

    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t d;
        d = '{value: 32'd0, exp_len: LEN_BAD, bad: 1'b0};
        priority casez (b)
            8'b0???????: d = '{value: {25'd0, b[6:0]}, exp_len: LEN_1, bad: 1'b0};
            8'b10??????: d = '{value: {26'd0, b[5:0]}, exp_len: LEN_BAD, bad: 1'b1};
            8'b110?????: d = '{value: {27'd0, b[4:0]}, exp_len: LEN_2, bad: 1'b0};
            8'b1110????: d = '{value: {28'd0, b[3:0]}, exp_len: LEN_3, bad: 1'b0};
            8'b11110???: d = '{value: {29'd0, b[2:0]}, exp_len: LEN_4, bad: 1'b0};
            8'b111110??: d = '{value: {30'd0, b[1:0]}, exp_len: LEN_5, bad: 1'b0};
            8'b1111110?: d = '{value: {31'd0, b[0]},   exp_len: LEN_6, bad: 1'b0};
            default:     d = '{value: 32'd0,           exp_len: LEN_BAD, bad: 1'b1};
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

[rtl/u8sd_core.sv]
// Decoder state and per-byte decode: accumulates a character and forms its results.
`default_nettype none
module u8sd_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_buffer,
    output u8sd_pkg::result_pair_t     results
);
    import u8sd_pkg::*;

    logic        pending_reg, pending_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  exp_reg, exp_next;
    logic [3:0]  seen_reg, seen_next;
    logic        bad_reg, bad_next;

    logic    is_cont, absorb, emit_prev;
    lead_t   lead;
    result_t prev_res, cur_res;

    assign is_cont   = (data_byte & CONT_MASK) == CONT_CODE;
    assign absorb    = is_cont && pending_reg;
    assign emit_prev = pending_reg && !absorb;
    assign lead      = decode_lead(data_byte);

    always_comb begin
        if (absorb) begin
            acc_next  = {acc_reg[25:0], data_byte[5:0]};
            seen_next = (seen_reg == COUNT_SAT) ? seen_reg : seen_reg + 4'd1;
            exp_next  = exp_reg;
            bad_next  = bad_reg;
        end else begin
            acc_next  = lead.value;
            seen_next = 4'd1;
            exp_next  = lead.exp_len;
            bad_next  = lead.bad;
        end
        pending_next = !end_of_buffer;
    end

    always_comb begin
        prev_res.code_point      = acc_reg;
        prev_res.byte_count      = seen_reg;
        prev_res.length_mismatch = seen_reg != {1'b0, exp_reg};
        prev_res.bad_lead        = bad_reg;
        prev_res.last_of_run     = !end_of_buffer;

        cur_res.code_point      = acc_next;
        cur_res.byte_count      = seen_next;
        cur_res.length_mismatch = seen_next != {1'b0, exp_next};
        cur_res.bad_lead        = bad_next;
        cur_res.last_of_run     = 1'b1;

        results.count  = {1'b0, emit_prev} + {1'b0, end_of_buffer};
        results.first  = emit_prev ? prev_res : cur_res;
        results.second = cur_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            acc_reg     <= '0;
            exp_reg     <= '0;
            seen_reg    <= '0;
            bad_reg     <= 1'b0;
        end else if (step) begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            exp_reg     <= exp_next;
            seen_reg    <= seen_next;
            bad_reg     <= bad_next;
        end
    end

`ifndef SYNTHESIS
    a_eob_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_buffer |=> !pending_reg)
        else $error("character still pending after end-of-buffer");
    a_eob_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_buffer |-> results.count != 2'd0)
        else $error("end-of-buffer byte produced no result");
    a_pending_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> seen_reg != 4'd0)
        else $error("pending character with zero byte count");
`endif

endmodule
`default_nettype wire

[rtl/u8sd_result_fifo.sv]
// Result queue: takes up to two results per cycle, delivers one per transfer.
`default_nettype none
module u8sd_result_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire u8sd_pkg::result_pair_t push_data,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output u8sd_pkg::result_t          out_data
);
    import u8sd_pkg::*;

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n    = push ? push_data.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign room      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_data.first;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_reg + FIFO_AW'(1)] <= push_data.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("result queue written without room");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue count out of range");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])
        else $error("result queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

[rtl/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder top level: input register, decode core and result queue.
//
// Accepts one byte per transfer, one per cycle when results drain as fast as they
// are produced. A byte is held in an input register, decoded once the queue has
// room, and its results (none, one or two) enter a four-entry queue that drives
// the m_ channel; the first result is offered on m_ once it has been written
// into the queue.
// An input byte is decoded only while the queue has room for two results, so the
// sustained rate is one byte per cycle unless two-result bytes (end-of-buffer on
// a new lead) or m_ready stalls outpace the one-result-per-cycle output port.
`default_nettype none
module utf8_stream_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_buffer,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_code_point,
    output logic [3:0]       m_byte_count,
    output logic             m_length_mismatch,
    output logic             m_bad_lead,
    output logic             m_last_of_run
);
    import u8sd_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   byte_reg;
    logic         eob_reg;
    logic         room, step, s_fire;
    result_pair_t results;
    result_t      out_res;

    assign step    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg <= s_data_byte;
            eob_reg  <= s_end_of_buffer;
        end
    end

    u8sd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .data_byte     (byte_reg),
        .end_of_buffer (eob_reg),
        .results       (results)
    );

    u8sd_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (results),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_code_point      = out_res.code_point;
    assign m_byte_count      = out_res.byte_count;
    assign m_length_mismatch = out_res.length_mismatch;
    assign m_bad_lead        = out_res.bad_lead;
    assign m_last_of_run     = out_res.last_of_run;

`ifndef SYNTHESIS
    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !room |=> in_valid_reg && $stable(byte_reg) && $stable(eob_reg))
        else $error("held input byte lost while queue full");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input not ready with empty input register");
    a_step_then_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step && eob_reg |=> m_valid)
        else $error("end-of-buffer byte decoded but no result queued");
`endif

endmodule
`default_nettype wire

[test/u8sd_stream_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 stream decoder: predicts results and compares output transfers.
module u8sd_stream_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_buffer,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_code_point,
    input  wire logic [3:0]  m_byte_count,
    input  wire logic        m_length_mismatch,
    input  wire logic        m_bad_lead,
    input  wire logic        m_last_of_run,
    output int               err_count,
    output int               outstanding
);
    import u8sd_pkg::*;

    result_t     char_q[$];

    // decoder state as seen by the scoreboard
    logic        chr_busy;
    logic [31:0] acc;
    logic [2:0]  want_len;
    logic [3:0]  nbytes;
    logic        lead_bad;

    initial begin
        err_count   = 0;
        outstanding = 0;
    end

    function automatic result_t close_char();
        result_t r;
        r.code_point      = acc;
        r.byte_count      = nbytes;
        r.length_mismatch = (nbytes != {1'b0, want_len});
        r.bad_lead        = lead_bad;
        r.last_of_run     = 1'b0;
        chr_busy = 1'b0;
        return r;
    endfunction

    task automatic decode_transfer(input logic [7:0] b, input logic eob);
        result_t done[2];
        int      n;
        int      i;
        n = 0;
        if ((b & CONT_MASK) == CONT_CODE && chr_busy) begin
            acc = {acc[25:0], b[5:0]};
            if (nbytes != COUNT_SAT) begin
                nbytes = nbytes + 4'd1;
            end
        end else begin
            if (chr_busy) begin
                done[n] = close_char();
                n++;
            end
            chr_busy = 1'b1;
            nbytes   = 4'd1;
            lead_bad = 1'b0;
            if (!b[7]) begin
                acc      = {25'd0, b[6:0]};
                want_len = LEN_1;
            end else if (!b[6]) begin
                // stray continuation opens a bad character
                acc      = {26'd0, b[5:0]};
                want_len = LEN_BAD;
                lead_bad = 1'b1;
            end else if (!b[5]) begin
                acc      = {27'd0, b[4:0]};
                want_len = LEN_2;
            end else if (!b[4]) begin
                acc      = {28'd0, b[3:0]};
                want_len = LEN_3;
            end else if (!b[3]) begin
                acc      = {29'd0, b[2:0]};
                want_len = LEN_4;
            end else if (!b[2]) begin
                acc      = {30'd0, b[1:0]};
                want_len = LEN_5;
            end else if (!b[1]) begin
                acc      = {31'd0, b[0]};
                want_len = LEN_6;
            end else begin
                acc      = 32'd0;
                want_len = LEN_BAD;
                lead_bad = 1'b1;
            end
        end
        if (eob && chr_busy) begin
            done[n] = close_char();
            n++;
        end
        if (n > 0) begin
            done[n - 1].last_of_run = 1'b1;
        end
        for (i = 0; i < n; i++) begin
            char_q.push_back(done[i]);
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            char_q.delete();
            chr_busy = 1'b0;
            acc      = 32'd0;
            want_len = LEN_BAD;
            nbytes   = 4'd0;
            lead_bad = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected result transfer: code_point 0x%0h", m_code_point);
                    err_count++;
                end else begin
                    want = char_q.pop_front();
                    check_field("code_point", want.code_point, m_code_point);
                    check_field("byte_count", want.byte_count, m_byte_count);
                    check_field("length_mismatch", want.length_mismatch, m_length_mismatch);
                    check_field("bad_lead", want.bad_lead, m_bad_lead);
                    check_field("last_of_run", want.last_of_run, m_last_of_run);
                end
            end
            if (s_valid && s_ready) begin
                decode_transfer(s_data_byte, s_end_of_buffer);
            end
        end
        outstanding = char_q.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the UTF-8 stream decoder: clock, reset, stimulus, back-pressure, verdict.
module tb_top;

    localparam int ITEM_TARGET  = 725;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 12;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_end_of_buffer;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_code_point;
    logic [3:0]  m_byte_count;
    logic        m_length_mismatch;
    logic        m_bad_lead;
    logic        m_last_of_run;

    int          err_count;
    int          outstanding;
    int          items_sent = 0;
    int          cycle_cnt = 0;
    int          tx_gap_pct = 20;
    int          rx_gap_pct = 20;
    logic        s_took = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    utf8_stream_decoder_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_buffer   (s_end_of_buffer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_point      (m_code_point),
        .m_byte_count      (m_byte_count),
        .m_length_mismatch (m_length_mismatch),
        .m_bad_lead        (m_bad_lead),
        .m_last_of_run     (m_last_of_run)
    );

    u8sd_stream_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_buffer   (s_end_of_buffer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_point      (m_code_point),
        .m_byte_count      (m_byte_count),
        .m_length_mismatch (m_length_mismatch),
        .m_bad_lead        (m_bad_lead),
        .m_last_of_run     (m_last_of_run),
        .err_count         (err_count),
        .outstanding       (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        s_took    <= s_valid && s_ready;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] rnd;
        rnd = 8'($urandom_range(0, 255));
        case (len)
            1:       return {1'b0, rnd[6:0]};
            2:       return {3'b110, rnd[4:0]};
            3:       return {4'b1110, rnd[3:0]};
            4:       return {5'b11110, rnd[2:0]};
            5:       return {6'b111110, rnd[1:0]};
            default: return {7'b1111110, rnd[0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] rnd;
        rnd = 8'($urandom_range(0, 255));
        return {2'b10, rnd[5:0]};
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic push_byte(input logic [7:0] b, input logic eob);
        int gap;
        if (tx_gap_pct != 0 && coin(tx_gap_pct)) begin
            gap = $urandom_range(1, 4);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data_byte     = b;
        s_end_of_buffer = eob;
        do @(negedge aclk); while (!s_took);
        items_sent++;
    endtask

    task automatic send_char();
        int   kind;
        int   len;
        int   conts;
        logic [7:0] rnd;
        kind  = $urandom_range(0, 99);
        len   = $urandom_range(1, 6);
        conts = 0;
        if (kind < 60) begin
            push_byte(lead_byte(len), coin(6));
            conts = len - 1;
        end else if (kind < 72) begin
            push_byte(lead_byte(len), coin(6));
            conts = $urandom_range(0, len + 2);
        end else if (kind < 78) begin
            // long runs saturate the count and wrap the code point
            push_byte(lead_byte(len), coin(6));
            conts = $urandom_range(14, 20);
        end else if (kind < 84) begin
            push_byte(coin(50) ? 8'hFE : 8'hFF, coin(6));
            conts = $urandom_range(0, 2);
        end else if (kind < 92) begin
            // flush, so the continuation that follows is stray
            push_byte(lead_byte(1), 1'b1);
            conts = $urandom_range(1, 3);
        end else begin
            rnd = 8'($urandom_range(0, 255));
            push_byte(rnd, coin(25));
        end
        repeat (conts) push_byte(cont_byte(), coin(6));
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_ready   = 1'b1;
            end else if (rx_gap_pct != 0 && coin(rx_gap_pct)) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data_byte     = 8'h00;
        s_end_of_buffer = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        push_byte(8'h80, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFC, 1'b0);
        push_byte(8'h84, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h41, 1'b1);
        push_byte(8'hBF, 1'b0);
        push_byte(8'h80, 1'b1);

        hold_req = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent < 300) begin
                tx_gap_pct = 25;
                rx_gap_pct = 25;
            end else if (items_sent < 450) begin
                tx_gap_pct = 0;
                rx_gap_pct = 40;
            end else if (items_sent < 600) begin
                tx_gap_pct = 40;
                rx_gap_pct = 10;
            end else begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            send_char();
        end
        s_valid = 1'b0;

        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/u8sd_pkg.sv
rtl/u8sd_core.sv
rtl/u8sd_result_fifo.sv
rtl/utf8_stream_decoder_unit.sv
test/u8sd_stream_checker.sv
test/tb_top.sv
